[hdl/s2rmd_pkg.sv]
// Types, constants and lookup tables for the scalar two-register-misc decoder.
package s2rmd_pkg;

    typedef enum logic [5:0] {
        MN_SUQADD  = 6'd0,  MN_SQABS   = 6'd1,  MN_SQXTN   = 6'd2,  MN_USQADD  = 6'd3,
        MN_SQNEG   = 6'd4,  MN_SQXTUN  = 6'd5,  MN_UQXTN   = 6'd6,  MN_FCVTNS  = 6'd7,
        MN_FCVTMS  = 6'd8,  MN_FCVTAS  = 6'd9,  MN_SCVTF   = 6'd10, MN_FCMGT   = 6'd11,
        MN_FCMEQ   = 6'd12, MN_FCMLT   = 6'd13, MN_FCVTPS  = 6'd14, MN_FCVTZS  = 6'd15,
        MN_FRECPE  = 6'd16, MN_FRECPX  = 6'd17, MN_CMGT    = 6'd18, MN_CMEQ    = 6'd19,
        MN_CMLT    = 6'd20, MN_ABS     = 6'd21, MN_FCVTNU  = 6'd22, MN_FCVTMU  = 6'd23,
        MN_FCVTAU  = 6'd24, MN_UCVTF   = 6'd25, MN_FCVTXN  = 6'd26, MN_FCMGE   = 6'd27,
        MN_FCMLE   = 6'd28, MN_FCVTPU  = 6'd29, MN_FCVTZU  = 6'd30, MN_FRSQRTE = 6'd31,
        MN_CMGE    = 6'd32, MN_CMLE    = 6'd33, MN_NEG     = 6'd34
    } mnem_t;

    typedef enum logic [1:0] {
        ZERO_NONE  = 2'd0,
        ZERO_INT   = 2'd1,
        ZERO_FLOAT = 2'd2
    } zero_t;

    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;
    localparam logic [1:0] SIZE_RESERVED = 2'd3;

    localparam logic [4:0] OPC_SUQADD   = 5'b00011;
    localparam logic [4:0] OPC_SQABS    = 5'b00111;
    localparam logic [4:0] OPC_NO_ZERO  = 5'b01011;
    localparam logic [4:0] OPC_FZERO_LO = 5'b01100;
    localparam logic [4:0] OPC_FZERO_HI = 5'b01110;

    typedef struct packed {
        logic       u;
        logic [1:0] size;
        logic [4:0] opc;
        logic [4:0] rn;
        logic [4:0] rd;
    } fields_t;

    typedef struct packed {
        logic  hit;
        mnem_t id;
    } hit_t;

    typedef struct packed {
        fields_t f;
        hit_t    sat;
        hit_t    sized;
    } lookup_t;

    typedef struct packed {
        logic       illegal;
        mnem_t      id;
        logic [4:0] rd;
        logic [4:0] rn;
        logic [1:0] dw;
        logic [1:0] sw;
        zero_t      zero;
    } result_t;

    // keyed by U:opcode
    function automatic hit_t sat_lookup(input logic [5:0] key);
        hit_t r;
        r.hit = 1'b1;
        r.id  = MN_SUQADD;
        unique case (key) inside
            6'h03:   r.id = MN_SUQADD;
            6'h07:   r.id = MN_SQABS;
            6'h14:   r.id = MN_SQXTN;
            6'h23:   r.id = MN_USQADD;
            6'h27:   r.id = MN_SQNEG;
            6'h32:   r.id = MN_SQXTUN;
            6'h34:   r.id = MN_UQXTN;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // keyed by U:size:opcode
    function automatic hit_t size_lookup(input logic [7:0] key);
        hit_t r;
        r.hit = 1'b1;
        r.id  = MN_FCVTNS;
        unique case (key) inside
            8'h1A, 8'h3A: r.id = MN_FCVTNS;
            8'h1B, 8'h3B: r.id = MN_FCVTMS;
            8'h1C, 8'h3C: r.id = MN_FCVTAS;
            8'h1D, 8'h3D: r.id = MN_SCVTF;
            8'h4C, 8'h6C: r.id = MN_FCMGT;
            8'h4D, 8'h6D: r.id = MN_FCMEQ;
            8'h4E, 8'h6E: r.id = MN_FCMLT;
            8'h5A, 8'h7A: r.id = MN_FCVTPS;
            8'h5B, 8'h7B: r.id = MN_FCVTZS;
            8'h5D, 8'h7D: r.id = MN_FRECPE;
            8'h5F, 8'h7F: r.id = MN_FRECPX;
            8'h68:        r.id = MN_CMGT;
            8'h69:        r.id = MN_CMEQ;
            8'h6A:        r.id = MN_CMLT;
            8'h6B:        r.id = MN_ABS;
            8'h9A, 8'hBA: r.id = MN_FCVTNU;
            8'h9B, 8'hBB: r.id = MN_FCVTMU;
            8'h9C, 8'hBC: r.id = MN_FCVTAU;
            8'h9D, 8'hBD: r.id = MN_UCVTF;
            8'hB6:        r.id = MN_FCVTXN;
            8'hCC, 8'hEC: r.id = MN_FCMGE;
            8'hCD, 8'hED: r.id = MN_FCMLE;
            8'hDA, 8'hFA: r.id = MN_FCVTPU;
            8'hDB, 8'hFB: r.id = MN_FCVTZU;
            8'hDD, 8'hFD: r.id = MN_FRSQRTE;
            8'hE8:        r.id = MN_CMGE;
            8'hE9:        r.id = MN_CMLE;
            8'hEB:        r.id = MN_NEG;
            default:      r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hdl/s2rmd_extract.sv]
// Stage 1: field extraction register.
module s2rmd_extract
    import s2rmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [31:0] word_in,
    output logic        ready_up,
    input  logic        ready_dn,
    output logic        valid_out,
    output fields_t     data_out
);

    logic    valid_reg;
    fields_t data_reg;
    fields_t data_next;

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        data_next.u    = word_in[29];
        data_next.size = word_in[23:22];
        data_next.opc  = word_in[16:12];
        data_next.rn   = word_in[9:5];
        data_next.rd   = word_in[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[hdl/s2rmd_lookup.sv]
// Stage 2: mnemonic table lookups.
module s2rmd_lookup
    import s2rmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    valid_in,
    input  fields_t data_in,
    output logic    ready_up,
    input  logic    ready_dn,
    output logic    valid_out,
    output lookup_t data_out
);

    logic    valid_reg;
    lookup_t data_reg;
    lookup_t data_next;

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        data_next.f     = data_in;
        data_next.sat   = sat_lookup({data_in.u, data_in.opc});
        data_next.sized = size_lookup({data_in.u, data_in.size, data_in.opc});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[hdl/s2rmd_format.sv]
// Stage 3: legality, operand widths and zero operand; output register.
module s2rmd_format
    import s2rmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    valid_in,
    input  lookup_t data_in,
    output logic    ready_up,
    input  logic    ready_dn,
    output logic    valid_out,
    output result_t data_out
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    fields_t f;
    logic    same_width;
    logic    has_zero;
    logic    float_zero;
    logic [1:0] wc;

    assign ready_up = !valid_reg || ready_dn;
    assign f        = data_in.f;

    always_comb
    begin
        same_width = (f.opc == OPC_SUQADD) || (f.opc == OPC_SQABS);
        has_zero   = (f.opc != OPC_NO_ZERO) && !f.opc[4];
        float_zero = (f.opc >= OPC_FZERO_LO) && (f.opc <= OPC_FZERO_HI);
        wc         = f.size[0] ? WIDTH_64 : WIDTH_32;

        data_next.illegal = 1'b0;
        data_next.id      = data_in.sat.id;
        data_next.rd      = f.rd;
        data_next.rn      = f.rn;
        data_next.dw      = f.size;
        data_next.sw      = f.size;
        data_next.zero    = ZERO_NONE;

        if (data_in.sat.hit)
        begin
            if (!same_width)
            begin
                data_next.sw = f.size + 2'd1;
            end
            if (!same_width && (f.size == SIZE_RESERVED))
            begin
                data_next.illegal = 1'b1;
            end
        end
        else if (!data_in.sized.hit)
        begin
            data_next.illegal = 1'b1;
        end
        else if (data_in.sized.id == MN_FCVTXN)
        begin
            data_next.id = data_in.sized.id;
            data_next.dw = WIDTH_32;
            data_next.sw = WIDTH_64;
        end
        else
        begin
            data_next.id = data_in.sized.id;
            data_next.dw = wc;
            data_next.sw = wc;
            if (has_zero)
            begin
                data_next.zero = float_zero ? ZERO_FLOAT : ZERO_INT;
            end
        end

        if (data_next.illegal)
        begin
            data_next.id   = MN_SUQADD;
            data_next.rd   = '0;
            data_next.rn   = '0;
            data_next.dw   = '0;
            data_next.sw   = '0;
            data_next.zero = ZERO_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[hdl/simd_scalar_two_reg_misc_decoder.sv]
// Scalar two-register-misc SIMD decoder, top level.
// Pipeline: three registered stages from input transfer to result valid (extract, lookup, format).
// Throughput: one instruction word per cycle; each stage holds under output stall.
// Reset: rst_n asynchronous, active low; clears stage valid bits only.
// No storage beyond the three pipeline registers.
module simd_scalar_two_reg_misc_decoder
    import s2rmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] insn_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        illegal,
    output logic [5:0]  mnemonic_id,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src_reg,
    output logic [1:0]  dest_width_code,
    output logic [1:0]  src_width_code,
    output logic [1:0]  zero_operand
);

    logic    s1_ready;
    logic    s1_valid;
    fields_t s1_data;
    logic    s2_ready;
    logic    s2_valid;
    lookup_t s2_data;
    logic    s3_ready;
    result_t s3_data;

    assign in_stall = !s1_ready;

    s2rmd_extract u_extract
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .word_in   (insn_word),
        .ready_up  (s1_ready),
        .ready_dn  (s2_ready),
        .valid_out (s1_valid),
        .data_out  (s1_data)
    );

    s2rmd_lookup u_lookup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .data_in   (s1_data),
        .ready_up  (s2_ready),
        .ready_dn  (s3_ready),
        .valid_out (s2_valid),
        .data_out  (s2_data)
    );

    s2rmd_format u_format
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .data_in   (s2_data),
        .ready_up  (s3_ready),
        .ready_dn  (!out_stall),
        .valid_out (out_valid),
        .data_out  (s3_data)
    );

    assign illegal         = s3_data.illegal;
    assign mnemonic_id     = s3_data.id;
    assign dest_reg        = s3_data.rd;
    assign src_reg         = s3_data.rn;
    assign dest_width_code = s3_data.dw;
    assign src_width_code  = s3_data.sw;
    assign zero_operand    = s3_data.zero;

endmodule

[tb/sv/tb_simd_scalar_two_reg_misc_decoder.sv]
// Self-checking testbench for the scalar two-register-misc SIMD decoder.
module tb_simd_scalar_two_reg_misc_decoder
    import s2rmd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CLASS_BITS = 32'h5E20_0800;
    localparam logic [31:0] FIELD_MASK = 32'h20C1_F3FF;

    localparam logic [4:0] OPC_CMGT_GE   = 5'b01000;
    localparam logic [4:0] OPC_CMEQ_LE   = 5'b01001;
    localparam logic [4:0] OPC_CMLT      = 5'b01010;
    localparam logic [4:0] OPC_FCMEQ_LE  = 5'b01101;
    localparam logic [4:0] OPC_XTUN      = 5'b10010;
    localparam logic [4:0] OPC_XTN       = 5'b10100;
    localparam logic [4:0] OPC_FCVTXN    = 5'b10110;
    localparam logic [4:0] OPC_FCVTN_P   = 5'b11010;
    localparam logic [4:0] OPC_FCVTM_Z   = 5'b11011;
    localparam logic [4:0] OPC_FCVTA     = 5'b11100;
    localparam logic [4:0] OPC_CVTF_EST  = 5'b11101;
    localparam logic [4:0] OPC_FRECPX    = 5'b11111;

    localparam logic [16:0][4:0] LIVE_OPCS = {
        OPC_SUQADD, OPC_SQABS, OPC_CMGT_GE, OPC_CMEQ_LE, OPC_CMLT, OPC_NO_ZERO,
        OPC_FZERO_LO, OPC_FCMEQ_LE, OPC_FZERO_HI, OPC_XTUN, OPC_XTN, OPC_FCVTXN,
        OPC_FCVTN_P, OPC_FCVTM_Z, OPC_FCVTA, OPC_CVTF_EST, OPC_FRECPX
    };

    localparam result_t ILLEGAL_RESULT = '{illegal: 1'b1, id: MN_SUQADD, zero: ZERO_NONE,
                                           default: '0};

    localparam int N_DIR          = 25;
    localparam int N_RANDOM       = 1375;
    localparam int N_CALM         = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 200;

    typedef struct packed {
        logic        known_bad;
        logic [31:0] word;
    } row_t;

    typedef struct {
        logic [31:0] word;
        result_t     res;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] insn_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        illegal;
    logic [5:0]  mnemonic_id;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [1:0]  dest_width_code;
    logic [1:0]  src_width_code;
    logic [1:0]  zero_operand;

    pending_t pending_decodes[$];
    int       mismatches = 0;
    int       in_gap_pct = 0;
    int       stall_pct = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;

    simd_scalar_two_reg_misc_decoder u_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] enc(input logic u, input logic [1:0] size,
                                        input logic [4:0] opc, input logic [4:0] rn,
                                        input logic [4:0] rd);
        return CLASS_BITS | {2'b0, u, 5'b0, size, 5'b0, opc, 2'b0, rn, rd};
    endfunction

    function automatic result_t decode_insn(input logic [31:0] w);
        result_t    r;
        logic       u;
        logic [1:0] size;
        logic [4:0] opc;
        logic       ok;
        logic       narrow;
        logic       hi;
        logic       full;
        mnem_t      id;
        u      = w[29];
        size   = w[23:22];
        opc    = w[16:12];
        hi     = size[1];
        full   = (size == SIZE_RESERVED);
        r      = '0;
        ok     = 1'b1;
        narrow = 1'b0;
        id     = MN_SUQADD;

        // saturating / narrowing group, keyed by U:opcode
        case (opc)
            OPC_SUQADD: id = u ? MN_USQADD : MN_SUQADD;
            OPC_SQABS:  id = u ? MN_SQNEG : MN_SQABS;
            OPC_XTN:
            begin
                id = u ? MN_UQXTN : MN_SQXTN;
                narrow = 1'b1;
            end
            OPC_XTUN:
            begin
                id = MN_SQXTUN;
                narrow = 1'b1;
                ok = u;
            end
            default: ok = 1'b0;
        endcase
        if (ok)
        begin
            if (narrow && full)
            begin
                r.illegal = 1'b1;
                return r;
            end
            r.id = id;
            r.rd = w[4:0];
            r.rn = w[9:5];
            r.dw = size;
            r.sw = narrow ? size + 2'd1 : size;
            return r;
        end

        // size-keyed group
        ok = 1'b1;
        case (opc)
            OPC_CMGT_GE:
            begin
                id = u ? MN_CMGE : MN_CMGT;
                ok = full;
            end
            OPC_CMEQ_LE:
            begin
                id = u ? MN_CMLE : MN_CMEQ;
                ok = full;
            end
            OPC_CMLT:
            begin
                id = MN_CMLT;
                ok = full && !u;
            end
            OPC_NO_ZERO:
            begin
                id = u ? MN_NEG : MN_ABS;
                ok = full;
            end
            OPC_FZERO_LO:
            begin
                id = u ? MN_FCMGE : MN_FCMGT;
                ok = hi;
            end
            OPC_FCMEQ_LE:
            begin
                id = u ? MN_FCMLE : MN_FCMEQ;
                ok = hi;
            end
            OPC_FZERO_HI:
            begin
                id = MN_FCMLT;
                ok = hi && !u;
            end
            OPC_FCVTXN:
            begin
                id = MN_FCVTXN;
                ok = u && size == 2'd1;
            end
            OPC_FCVTN_P:  id = hi ? (u ? MN_FCVTPU : MN_FCVTPS) : (u ? MN_FCVTNU : MN_FCVTNS);
            OPC_FCVTM_Z:  id = hi ? (u ? MN_FCVTZU : MN_FCVTZS) : (u ? MN_FCVTMU : MN_FCVTMS);
            OPC_FCVTA:
            begin
                id = u ? MN_FCVTAU : MN_FCVTAS;
                ok = !hi;
            end
            OPC_CVTF_EST: id = hi ? (u ? MN_FRSQRTE : MN_FRECPE) : (u ? MN_UCVTF : MN_SCVTF);
            OPC_FRECPX:
            begin
                id = MN_FRECPX;
                ok = hi && !u;
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
        begin
            r.illegal = 1'b1;
            return r;
        end
        r.id = id;
        r.rd = w[4:0];
        r.rn = w[9:5];
        if (opc == OPC_FCVTXN)
        begin
            r.dw = WIDTH_32;
            r.sw = WIDTH_64;
        end
        else
        begin
            r.dw = size[0] ? WIDTH_64 : WIDTH_32;
            r.sw = r.dw;
            if (opc != OPC_NO_ZERO && !opc[4])
                r.zero = (opc >= OPC_FZERO_LO && opc <= OPC_FZERO_HI) ? ZERO_FLOAT : ZERO_INT;
        end
        return r;
    endfunction

    row_t dir_rows [N_DIR] = '{
        '{1'b1, 32'h0000_0000},
        '{1'b1, 32'hFFFF_FFFF},
        '{1'b0, enc(1'b0, 2'd0, OPC_SUQADD, 5'd0, 5'd31)},
        '{1'b0, enc(1'b0, 2'd3, OPC_SQABS, 5'd31, 5'd0)},
        '{1'b0, enc(1'b0, 2'd0, OPC_XTN, 5'd5, 5'd10)},
        '{1'b1, enc(1'b0, SIZE_RESERVED, OPC_XTN, 5'd7, 5'd7)},
        '{1'b0, enc(1'b1, 2'd1, OPC_SUQADD, 5'd21, 5'd10)},
        '{1'b0, enc(1'b1, 2'd2, OPC_SQABS, 5'd3, 5'd28)},
        '{1'b0, enc(1'b1, 2'd2, OPC_XTUN, 5'd14, 5'd17)},
        '{1'b1, enc(1'b1, SIZE_RESERVED, OPC_XTUN, 5'd1, 5'd2)},
        '{1'b0, enc(1'b1, 2'd1, OPC_XTN, 5'd30, 5'd1)},
        '{1'b1, enc(1'b0, 2'd2, OPC_XTUN, 5'd9, 5'd9)},
        '{1'b0, enc(1'b0, 2'd2, OPC_FZERO_LO, 5'd11, 5'd22)},
        '{1'b0, enc(1'b0, 2'd3, OPC_CMEQ_LE, 5'd16, 5'd15)},
        '{1'b0, enc(1'b0, 2'd3, OPC_NO_ZERO, 5'd8, 5'd4)},
        '{1'b0, enc(1'b1, 2'd3, OPC_NO_ZERO, 5'd4, 5'd8)},
        '{1'b1, enc(1'b0, 2'd2, OPC_CMGT_GE, 5'd6, 5'd6)},
        '{1'b0, enc(1'b1, 2'd1, OPC_FCVTXN, 5'd27, 5'd13)},
        '{1'b1, enc(1'b1, 2'd0, OPC_FCVTXN, 5'd27, 5'd13)},
        '{1'b0, enc(1'b0, 2'd3, OPC_FRECPX, 5'd19, 5'd23)},
        '{1'b0, enc(1'b1, 2'd2, OPC_CVTF_EST, 5'd25, 5'd26)},
        '{1'b0, enc(1'b1, 2'd0, OPC_FCVTN_P, 5'd31, 5'd0)},
        '{1'b0, enc(1'b1, 2'd3, OPC_FCMEQ_LE, 5'd12, 5'd29)},
        '{1'b0, enc(1'b0, 2'd1, OPC_CVTF_EST, 5'd18, 5'd20)},
        '{1'b0, enc(1'b0, 2'd3, OPC_CMLT, 5'd17, 5'd12) ^ ~FIELD_MASK}
    };

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] word,
                               input logic [5:0] got, input logic [5:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %08h %s: got %0d expected %0d",
                                      word, name, got, want));
    endtask

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_word(input logic [31:0] w, input logic known_bad);
        pending_t p;
        if ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        insn_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        p.word = w;
        p.res  = known_bad ? ILLEGAL_RESULT : decode_insn(w);
        pending_decodes.push_back(p);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 19);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        pending_t p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer: illegal=%0b id=%0d",
                                          illegal, mnemonic_id));
            end
            else
            begin
                p = pending_decodes.pop_front();
                check_field("illegal", p.word, 6'(illegal), 6'(p.res.illegal));
                check_field("mnemonic_id", p.word, mnemonic_id, p.res.id);
                check_field("dest_reg", p.word, 6'(dest_reg), 6'(p.res.rd));
                check_field("src_reg", p.word, 6'(src_reg), 6'(p.res.rn));
                check_field("dest_width_code", p.word, 6'(dest_width_code), 6'(p.res.dw));
                check_field("src_width_code", p.word, 6'(src_width_code), 6'(p.res.sw));
                check_field("zero_operand", p.word, 6'(zero_operand), 6'(p.res.zero));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] w;
        logic [4:0]  opc;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_gap_pct = 10;
        stall_pct  = 10;
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].known_bad);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n >= N_RANDOM - N_CALM)
            begin
                in_gap_pct = 0;
                stall_pct  = 0;
            end
            else if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 5;
                    default: in_gap_pct = 25;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    default: stall_pct = 25;
                endcase
            end
            // mostly class-conforming words, some raw noise
            if ($urandom_range(0, 99) < 25)
            begin
                w = $urandom;
            end
            else
            begin
                opc = LIVE_OPCS[5'($urandom_range(0, 16))];
                w = enc(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), opc,
                        5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                if ($urandom_range(0, 7) == 0)
                    w ^= $urandom & ~FIELD_MASK;
            end
            send_word(w, 1'b0);
        end
        in_valid <= 1'b0;

        while (pending_decodes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/s2rmd_pkg.sv
hdl/s2rmd_extract.sv
hdl/s2rmd_lookup.sv
hdl/s2rmd_format.sv
hdl/simd_scalar_two_reg_misc_decoder.sv
tb/sv/tb_simd_scalar_two_reg_misc_decoder.sv
